### rtl/sgm_pkg.sv
// sgm_pkg.sv: shared types, constants and gradient function for the sobel magnitude block
`timescale 1ns / 1ps
package sgm_pkg;

   localparam int PIXEL_W   = 8;
   localparam int COORD_W   = 10;
   localparam int CSR_W     = 11;
   localparam logic [CSR_W-1:0] CSR_WIDTH_RESET = 11'd720;
   localparam int MIN_WIDTH = 3;
   localparam logic [9:0] MAG_MAX = 10'd255;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // one input item
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_of_frame;
   } sgm_req_type;

   // one result item
   typedef struct packed {
      logic [PIXEL_W-1:0] magnitude;
      logic [COORD_W-1:0] centre_col;
      logic [COORD_W-1:0] centre_row;
   } sgm_rsp_type;

   // (|gx| + |gy|) / 2 saturated to 255
   function automatic pixel_type sobel_mag(
      input pixel_type tl, input pixel_type ml, input pixel_type bl,
      input pixel_type tc, input pixel_type bc,
      input pixel_type tr, input pixel_type mr, input pixel_type br);
      logic [9:0]  xp;
      logic [9:0]  xn;
      logic [9:0]  yp;
      logic [9:0]  yn;
      logic [9:0]  ax;
      logic [9:0]  ay;
      logic [10:0] sum;
      logic [9:0]  half;
      xp   = {2'b00, tr} + {1'b0, mr, 1'b0} + {2'b00, br};
      xn   = {2'b00, tl} + {1'b0, ml, 1'b0} + {2'b00, bl};
      yp   = {2'b00, bl} + {1'b0, bc, 1'b0} + {2'b00, br};
      yn   = {2'b00, tl} + {1'b0, tc, 1'b0} + {2'b00, tr};
      ax   = (xp >= xn) ? (xp - xn) : (xn - xp);
      ay   = (yp >= yn) ? (yp - yn) : (yn - yp);
      sum  = {1'b0, ax} + {1'b0, ay};
      half = sum[10:1];
      return (half > MAG_MAX) ? MAG_MAX[PIXEL_W-1:0] : half[PIXEL_W-1:0];
   endfunction

endpackage

### rtl/sgm_ram.sv
// sgm_ram.sv: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module sgm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sgm_pos_cnt.sv
// sgm_pos_cnt.sv: width register and raster column / row counters
`timescale 1ns / 1ps
module sgm_pos_cnt #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [sgm_pkg::CSR_W-1:0] csr_wdata,
   input  logic                    advance,
   input  logic                    last_of_frame,
   output logic [COL_W-1:0]        col,
   output logic [ROW_W-1:0]        row
);
   import sgm_pkg::*;

   localparam int WCALC  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (WCALC > CSR_W) ? WCALC : CSR_W;
   localparam logic [CMP_W-1:0] W_MIN = CMP_W'(MIN_WIDTH);
   localparam logic [CMP_W-1:0] W_MAX = CMP_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

   logic [CSR_W-1:0] width_ff;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [CMP_W-1:0] width_raw;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] col_plus;

   // image width register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CSR_WIDTH_RESET;
      end else if (csr_we) begin
         width_ff <= csr_wdata;
      end
   end

   // clamp width to the supported range
   always_comb begin
      width_raw = CMP_W'(width_ff);
      if (width_raw < W_MIN) begin
         width_eff = W_MIN;
      end else if (width_raw > W_MAX) begin
         width_eff = W_MAX;
      end else begin
         width_eff = width_raw;
      end
   end

   // next position after the current item
   always_comb begin
      col_plus = CMP_W'(col_ff) + CMP_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (advance) begin
         priority if (last_of_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (col_plus >= width_eff) begin
            col_in = '0;
            if (row_ff < ROW_LAST) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

### rtl/sgm_kernel.sv
// sgm_kernel.sv: 3x3 window column registers and gradient magnitude logic
`timescale 1ns / 1ps
module sgm_kernel (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  sgm_pkg::pixel_type top,
   input  sgm_pkg::pixel_type mid,
   input  sgm_pkg::pixel_type bot,
   output sgm_pkg::pixel_type magnitude
);
   import sgm_pkg::*;

   // [0..2] two columns back (top, mid, bottom), [3..5] one column back
   pixel_type win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   // gradients with the incoming column as the right edge
   assign magnitude = sobel_mag(win_ff[0], win_ff[1], win_ff[2],
                                win_ff[3], win_ff[5],
                                top, mid, bot);

endmodule

### rtl/sobel_gradient_magnitude.sv
// sobel_gradient_magnitude.sv: streaming 3x3 sobel edge magnitude, top level
// Result path: an accepted item passes the input stage, then the result register.
// Throughput: one item per cycle while the result is not stalled; the line store reads
// are issued at accept and consumed in the input stage, with a bypass when that column is written then.
// Reset: counters to row 0 / column 0, width 720, window to zero, no result pending.
// Line stores are not cleared; entries are defined once written.
`timescale 1ns / 1ps
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sgm_pkg::sgm_req_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sgm_pkg::sgm_rsp_type      rsp_payload,
   input  logic                      csr_we,
   input  logic [sgm_pkg::CSR_W-1:0] csr_wdata
);
   import sgm_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic             accept;
   logic             out_free;
   logic             s1_move;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;

   logic             s1_valid_ff;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;

   logic             fwd_ff;
   pixel_type        fwd_top_ff;
   pixel_type        fwd_mid_ff;

   pixel_type        top_rd;
   pixel_type        mid_rd;
   pixel_type        top;
   pixel_type        mid;
   pixel_type        magnitude;
   logic             interior;
   logic [COL_W-1:0] centre_col;
   logic [ROW_W-1:0] centre_row;

   logic             rsp_valid_ff;
   sgm_rsp_type      rsp_payload_ff;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // raster position of the next item
   sgm_pos_cnt #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .advance       (accept),
      .last_of_frame (req_payload.last_of_frame),
      .col           (col),
      .row           (row)
   );

   // line stores: read at accept, written when the item leaves the input stage
   sgm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (mid_rd)
   );

   sgm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (top_rd)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_payload.pixel;
         s1_col_ff   <= col;
         s1_row_ff   <= row;
      end
   end

   // bypass when the read hits the column being written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (accept) begin
         fwd_ff <= s1_move && (s1_col_ff == col);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_top_ff <= mid;
         fwd_mid_ff <= s1_pixel_ff;
      end
   end

   assign top = fwd_ff ? fwd_top_ff : top_rd;
   assign mid = fwd_ff ? fwd_mid_ff : mid_rd;

   // window and magnitude
   sgm_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .shift     (s1_move),
      .top       (top),
      .mid       (mid),
      .bot       (s1_pixel_ff),
      .magnitude (magnitude)
   );

   assign interior   = (s1_row_ff >= ROW_W'(2)) && (s1_col_ff >= COL_W'(2));
   assign centre_col = s1_col_ff - COL_W'(1);
   assign centre_row = s1_row_ff - ROW_W'(1);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && interior) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && interior) begin
         rsp_payload_ff.magnitude  <= magnitude;
         rsp_payload_ff.centre_col <= COORD_W'(centre_col);
         rsp_payload_ff.centre_row <= COORD_W'(centre_row);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
